/* rtl/lzwsd_pkg.sv */
// Package for the LZ window stream decoder: request payload types,
// parse phase codes, error codes and format constants. No dependencies.
package lzwsd_pkg;

  // Fixed field widths
  localparam int unsigned SIZE_W  = 27;  // output size and byte counter
  localparam int unsigned DIST_W  = 13;  // distance plus one, up to 4096
  localparam int unsigned RUN_W   = 9;   // run length, up to 273
  localparam int unsigned COUNT_W = 4;   // byte count of one result
  localparam int unsigned DATA_W  = 64;  // packed result bytes

  // Format constants
  localparam logic [3:0]       FLAGS_PER_CODE = 4'd8;
  localparam logic [RUN_W-1:0] SHORT_BIAS     = 9'd2;
  localparam logic [RUN_W-1:0] LONG_BIAS      = 9'h12;

  // Parse phases
  localparam logic [1:0] PH_CODE   = 2'd0;
  localparam logic [1:0] PH_ITEM   = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;
  localparam logic [1:0] PH_THIRD  = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_NONE         = 2'd0;
  localparam logic [1:0] ERR_BEFORE_START = 2'd1;
  localparam logic [1:0] ERR_CLIPPED      = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_start;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0]  out_bytes;
    logic [COUNT_W-1:0] byte_count;
    logic               run_last;
    logic               stream_done;
    logic [1:0]         error_code;
  } out_item_t;

endpackage

/* rtl/lz_window_stream_decoder.sv */
// LZ window stream decoder top level: parser, copy sequencer, history window
// memory and output register. Depends on lzwsd_pkg.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | in        | in_valid_i / in_stall_o | in_i  (in_item_t)
//  out     | out       | out_valid_o/out_stall_i | out_o (out_item_t)
//  cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_data_i (output_size)
//
// A code byte or an ignored byte is taken in the idle state; a literal is accepted
// and then loaded into the output register. In a run each copied byte needs one
// read and one write of the single window memory, whose read data is registered,
// and each result of up to OUT_LANES bytes is loaded into the output register.
// Reset clears all control state; the window needs no clearing pass.
// A stalled output holds the sequencer in its load state; input stays stalled
// until the last result of the current request is in the output register.
module lz_window_stream_decoder #(
  parameter int unsigned WINDOW_BYTES = 4096,
  parameter int unsigned OUT_LANES    = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  lzwsd_pkg::in_item_t        in_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output lzwsd_pkg::out_item_t       out_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [lzwsd_pkg::SIZE_W-1:0] cfg_data_i
);
  import lzwsd_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_BYTES);
  localparam logic [COUNT_W-1:0] LANES = COUNT_W'(OUT_LANES);

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_WR   = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [SIZE_W-1:0]   size_q;
  logic [AW-1:0]       wp_q, wp_d;
  logic [SIZE_W-1:0]   bw_q, bw_d;
  logic [7:0]          flag_q, flag_d;
  logic [3:0]          left_q, left_d;
  logic [1:0]          phase_q, phase_d;
  logic [7:0]          hf_q, hf_d;
  logic [7:0]          hs_q, hs_d;
  logic [DIST_W-1:0]   d1_q, d1_d;
  logic [RUN_W-1:0]    rem_q, rem_d;
  logic [DATA_W-1:0]   acc_q, acc_d;
  logic [COUNT_W-1:0]  lanes_q, lanes_d;
  logic                zf_q, zf_d;
  logic                zsel_q, zsel_d;
  logic                last_q, last_d;
  logic                clip_q, clip_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q, out_d;

  // Window memory ports
  logic [7:0]          mem [WINDOW_BYTES];
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [7:0]          wr_data;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [7:0]          rdata_q;

  // Effective state of an accepted request after a stream start
  logic                accept;
  logic [AW-1:0]       wp_e;
  logic [SIZE_W-1:0]   bw_e;
  logic [7:0]          flag_e, hf_e, hs_e, b;
  logic [3:0]          left_e, nf_left;
  logic [1:0]          phase_e, nf_phase;
  logic [7:0]          nf_flag;

  // Copy step values
  logic [7:0]          cb;
  logic [SIZE_W-1:0]   bw_n;
  logic [RUN_W-1:0]    rem_n;
  logic [COUNT_W-1:0]  lanes_n;
  logic                done_n, end_n;
  logic                out_free;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Stream start clears parse state before the byte is taken
  always_comb begin
    b       = in_i.in_byte;
    wp_e    = in_i.stream_start ? '0 : wp_q;
    bw_e    = in_i.stream_start ? '0 : bw_q;
    flag_e  = in_i.stream_start ? '0 : flag_q;
    left_e  = in_i.stream_start ? '0 : left_q;
    phase_e = in_i.stream_start ? PH_CODE : phase_q;
    hf_e    = in_i.stream_start ? '0 : hf_q;
    hs_e    = in_i.stream_start ? '0 : hs_q;
    // advance to the next flag
    nf_flag  = {flag_e[6:0], 1'b0};
    nf_left  = (left_e != 4'd0) ? left_e - 4'd1 : left_e;
    nf_phase = (nf_left == 4'd0) ? PH_CODE : PH_ITEM;
  end

  // Copy step: byte from window or zero fill
  always_comb begin
    cb      = zsel_q ? 8'd0 : rdata_q;
    bw_n    = bw_q + SIZE_W'(1);
    rem_n   = rem_q - RUN_W'(1);
    lanes_n = lanes_q + COUNT_W'(1);
    done_n  = (bw_n >= size_q);
    end_n   = (rem_n == '0) || done_n;
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    bw_d        = bw_q;
    flag_d      = flag_q;
    left_d      = left_q;
    phase_d     = phase_q;
    hf_d        = hf_q;
    hs_d        = hs_q;
    d1_d        = d1_q;
    rem_d       = rem_q;
    acc_d       = acc_q;
    lanes_d     = lanes_q;
    zf_d        = zf_q;
    zsel_d      = zsel_q;
    last_d      = last_q;
    clip_d      = clip_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    wr_en       = 1'b0;
    wr_addr     = wp_q;
    wr_data     = cb;
    rd_en       = 1'b0;
    rd_addr     = wp_q - d1_q[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          wp_d    = wp_e;
          bw_d    = bw_e;
          flag_d  = flag_e;
          left_d  = left_e;
          phase_d = phase_e;
          hf_d    = hf_e;
          hs_d    = hs_e;
          if (bw_e < size_q) begin
            unique case (phase_e)
              PH_CODE: begin
                flag_d  = b;
                left_d  = FLAGS_PER_CODE;
                phase_d = PH_ITEM;
              end
              PH_ITEM: begin
                if (flag_e[7]) begin
                  // literal byte
                  wr_en   = 1'b1;
                  wr_addr = wp_e;
                  wr_data = b;
                  wp_d    = wp_e + AW'(1);
                  bw_d    = bw_e + SIZE_W'(1);
                  acc_d   = {{(DATA_W-8){1'b0}}, b};
                  lanes_d = COUNT_W'(1);
                  zf_d    = 1'b0;
                  last_d  = 1'b1;
                  clip_d  = 1'b0;
                  flag_d  = nf_flag;
                  left_d  = nf_left;
                  phase_d = nf_phase;
                  state_d = S_EMIT;
                end else begin
                  hf_d    = b;
                  phase_d = PH_SECOND;
                end
              end
              PH_SECOND: begin
                hs_d = b;
                if (hf_e[7:4] == 4'd0) begin
                  phase_d = PH_THIRD;
                end else begin
                  // short run, length from the high nibble
                  d1_d    = {1'b0, hf_e[3:0], b} + DIST_W'(1);
                  rem_d   = RUN_W'(hf_e[7:4]) + SHORT_BIAS;
                  acc_d   = '0;
                  lanes_d = '0;
                  zf_d    = 1'b0;
                  flag_d  = nf_flag;
                  left_d  = nf_left;
                  phase_d = nf_phase;
                  state_d = S_RD;
                end
              end
              PH_THIRD: begin
                // long run, length from the third byte
                d1_d    = {1'b0, hf_e[3:0], hs_e} + DIST_W'(1);
                rem_d   = RUN_W'(b) + LONG_BIAS;
                acc_d   = '0;
                lanes_d = '0;
                zf_d    = 1'b0;
                flag_d  = nf_flag;
                left_d  = nf_left;
                phase_d = nf_phase;
                state_d = S_RD;
              end
              default: ;
            endcase
          end
        end
      end
      S_RD: begin
        // fetch source byte, or zero when it lies before the stream start
        rd_en   = 1'b1;
        zsel_d  = ({{(SIZE_W-DIST_W){1'b0}}, d1_q} > bw_q);
        state_d = S_WR;
      end
      S_WR: begin
        wr_en   = 1'b1;
        wp_d    = wp_q + AW'(1);
        bw_d    = bw_n;
        rem_d   = rem_n;
        lanes_d = lanes_n;
        zf_d    = zf_q || zsel_q;
        for (int l = 0; l < OUT_LANES; l++) begin
          if (lanes_q == COUNT_W'(l)) acc_d[8*l +: 8] = cb;
        end
        if (lanes_n == LANES || end_n) begin
          last_d  = end_n;
          clip_d  = done_n && (rem_n != '0);
          state_d = S_EMIT;
        end else begin
          state_d = S_RD;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.out_bytes   = acc_q;
          out_d.byte_count  = lanes_q;
          out_d.run_last    = last_q;
          out_d.stream_done = (bw_q >= size_q);
          out_d.error_code  = zf_q ? ERR_BEFORE_START :
                              (clip_q ? ERR_CLIPPED : ERR_NONE);
          acc_d   = '0;
          lanes_d = '0;
          zf_d    = 1'b0;
          state_d = last_q ? S_IDLE : S_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      size_q      <= '0;
      wp_q        <= '0;
      bw_q        <= '0;
      flag_q      <= '0;
      left_q      <= '0;
      phase_q     <= PH_CODE;
      hf_q        <= '0;
      hs_q        <= '0;
      lanes_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      bw_q        <= bw_d;
      flag_q      <= flag_d;
      left_q      <= left_d;
      phase_q     <= phase_d;
      hf_q        <= hf_d;
      hs_q        <= hs_d;
      lanes_q     <= lanes_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) size_q <= cfg_data_i;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    d1_q   <= d1_d;
    rem_q  <= rem_d;
    acc_q  <= acc_d;
    zf_q   <= zf_d;
    zsel_q <= zsel_d;
    last_q <= last_d;
    clip_q <= clip_d;
    out_q  <= out_d;
  end

  // History window: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  // Checks
  a_lanes_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lanes_q <= LANES)
    else $error("lane count above lane limit");

  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WR |-> $past(state_q) == S_RD)
    else $error("window write without preceding read");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.byte_count != '0) && (out_q.byte_count <= LANES))
    else $error("result byte count out of range");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.stream_done |-> out_q.run_last)
    else $error("stream finished on a result that is not the last");

endmodule
